// File: rtl/cct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants of the cheat table engine
// Beat structures, table geometry, command and status codes, hex decoding.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_ENABLE  = 3'd2;
  localparam logic [2:0] OP_DISABLE = 3'd3;
  localparam logic [2:0] OP_VBLANK  = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [7:0] CodeType = 8'h01;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] code_text;
    logic [31:0] code_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_value;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  value;
    logic [31:0] id;
    logic        enabled;
  } entry_t;

  // Ring control for one cycle of a table pass.
  typedef struct packed {
    logic   shift;
    logic   drop;
    logic   park;
    logic   sub;
    entry_t sub_data;
  } ring_ctl_t;

  // Returns {bad, nibble} for one ASCII hex character.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else begin
      r = 5'h1F;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cct_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cct_cell: one table slot of the rotating chain
// Holds one entry and loads either its right neighbor or the ring tail input.
// ----------------------------------------------------------------------------
module cct_cell (
  input  wire                 clk,
  input  wire                 load,
  input  wire                 take_tail,
  input  cct_pkg::entry_t     neighbor,
  input  cct_pkg::entry_t     tail,
  output cct_pkg::entry_t     entry
);
  import cct_pkg::*;

  entry_t slot;

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= take_tail ? tail : neighbor;
    end
  end

  assign entry = slot;

endmodule
`default_nettype wire

// File: rtl/cct_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cct_ring: chain of table cells
// Rotates the table one slot per cycle through the head cell while shift is
// set. In park mode the last cell holds still and the tail input enters one
// cell earlier, which closes the gap left by a dropped entry by the end of the pass.
// ----------------------------------------------------------------------------
module cct_ring (
  input  wire                 clk,
  input  cct_pkg::ring_ctl_t  ctl,
  output cct_pkg::entry_t     head
);
  import cct_pkg::*;

  entry_t cell_q [TableDepth];
  entry_t tail_in;

  assign head    = cell_q[0];
  assign tail_in = ctl.sub ? ctl.sub_data : cell_q[0];

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    if (i == TableDepth - 1) begin : g_last
      cct_cell u_cell (
        .clk       (clk),
        .load      (ctl.shift && !ctl.park && !ctl.drop),
        .take_tail (1'b1),
        .neighbor  (cell_q[i]),
        .tail      (tail_in),
        .entry     (cell_q[i])
      );
    end else if (i == TableDepth - 2) begin : g_second
      cct_cell u_cell (
        .clk       (clk),
        .load      (ctl.shift),
        .take_tail (ctl.park),
        .neighbor  (cell_q[i + 1]),
        .tail      (tail_in),
        .entry     (cell_q[i])
      );
    end else begin : g_mid
      cct_cell u_cell (
        .clk       (clk),
        .load      (ctl.shift),
        .take_tail (1'b0),
        .neighbor  (cell_q[i + 1]),
        .tail      (tail_in),
        .entry     (cell_q[i])
      );
    end
  end

endmodule
`default_nettype wire

// File: rtl/cheat_code_table_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cheat_code_table_engine: cheat entry table with vblank write-out
// Parses and stores cheat codes, edits them by id and emits memory writes.
// ----------------------------------------------------------------------------
//   channel   ports                     handshake
//   command   start, busy, command      beat taken when start && !busy
//   result    result_valid, result      one-cycle strobe, cannot be held off
//
// Add, remove, enable, disable and vblank rotate the whole table once through
// the head cell: a pass state that steps through every slot, then the closing
// state S_DONE, which registers the last result. Rejected adds, clear and
// unused codes skip the pass and go from idle straight to S_DONE. A vblank
// write is held until the next enabled entry shows that it is not the last one.
// Reset empties the table; the slots are not cleared. Results never stall.
// ----------------------------------------------------------------------------
module cheat_code_table_engine (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  output logic           busy,
  input  cct_pkg::cmd_t  command,
  output logic           result_valid,
  output cct_pkg::rsp_t  result
);
  import cct_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PASS, S_DONE} state_t;

  state_t          state;
  logic [2:0]      op;
  logic [31:0]     key;
  entry_t          add_entry;
  logic [2:0]      status;
  logic            found;
  logic [IdxW-1:0] k;
  logic [CntW-1:0] count;
  logic            pend_valid;
  logic [15:0]     pend_addr;
  logic [7:0]      pend_value;

  logic [3:0]      nib [8];
  logic            any_bad;
  entry_t          parsed;
  entry_t          head;
  ring_ctl_t       ctl;
  logic            live;
  logic            hit;
  logic [CntW-1:0] k_ext;

  // Character decode of the incoming add beat.
  always_comb begin
    logic [4:0] d;
    any_bad = 1'b0;
    for (int i = 0; i < 8; i++) begin
      d       = hex_nibble(command.code_text[8*i +: 8]);
      nib[i]  = d[3:0];
      any_bad = any_bad | d[4];
    end
    parsed.value   = {nib[2], nib[3]};
    parsed.addr    = {nib[4], nib[5], nib[6], nib[7]};
    parsed.id      = {nib[7], nib[6], nib[5], nib[4], nib[3], nib[2], nib[1], nib[0]};
    parsed.enabled = 1'b1;
  end

  assign k_ext = CntW'(k);
  assign live  = k_ext < count;
  assign hit   = live && !found && (head.id == key);

  always_comb begin
    ctl          = '0;
    ctl.sub_data = head;
    if (state == S_PASS) begin
      ctl.shift = 1'b1;
      ctl.park  = (op == OP_REMOVE) && found;
      ctl.drop  = (op == OP_REMOVE) && hit;
      if (op == OP_ADD && k_ext == count) begin
        ctl.sub      = 1'b1;
        ctl.sub_data = add_entry;
      end else if ((op == OP_ENABLE || op == OP_DISABLE) && hit) begin
        ctl.sub              = 1'b1;
        ctl.sub_data.enabled = (op == OP_ENABLE);
      end
    end
  end

  cct_ring u_ring (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      found        <= 1'b0;
      pend_valid   <= 1'b0;
      k            <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op         <= command.operation;
            key        <= command.code_id;
            add_entry  <= parsed;
            status     <= ST_OK;
            found      <= 1'b0;
            pend_valid <= 1'b0;
            k          <= '0;
            state      <= S_DONE;
            unique case (command.operation)
              OP_ADD: begin
                // Character errors win over the type check, which wins over capacity.
                if (any_bad) begin
                  status <= ST_BAD_CHAR;
                end else if ({nib[0], nib[1]} != CodeType) begin
                  status <= ST_BAD_TYPE;
                end else if (count >= CntW'(TableDepth)) begin
                  status <= ST_FULL;
                end else begin
                  state <= S_PASS;
                end
              end
              OP_REMOVE, OP_ENABLE, OP_DISABLE, OP_VBLANK: begin
                state <= S_PASS;
              end
              OP_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_PASS: begin
          if (hit) begin
            found <= 1'b1;
          end
          // A vblank write is held until the next one shows whether it is the last.
          if (op == OP_VBLANK && live && head.enabled) begin
            pend_valid <= 1'b1;
            pend_addr  <= head.addr;
            pend_value <= head.value;
            if (pend_valid) begin
              result_valid       <= 1'b1;
              result.status      <= ST_OK;
              result.result_id   <= '0;
              result.write_valid <= 1'b1;
              result.write_addr  <= pend_addr;
              result.write_value <= pend_value;
              result.last        <= 1'b0;
            end
          end
          if (k == IdxW'(TableDepth - 1)) begin
            state <= S_DONE;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DONE: begin
          result_valid       <= 1'b1;
          result.status      <= status;
          result.result_id   <= '0;
          result.write_valid <= 1'b0;
          result.write_addr  <= '0;
          result.write_value <= '0;
          result.last        <= 1'b1;
          if (op == OP_ADD && status == ST_OK) begin
            result.result_id <= add_entry.id;
            count            <= count + 1'b1;
          end
          if (op == OP_REMOVE || op == OP_ENABLE || op == OP_DISABLE) begin
            if (!found) begin
              result.status <= ST_NOT_FOUND;
            end else if (op == OP_REMOVE) begin
              count <= count - 1'b1;
            end
          end
          if (op == OP_VBLANK && pend_valid) begin
            result.write_valid <= 1'b1;
            result.write_addr  <= pend_addr;
            result.write_value <= pend_value;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: test/cheat_code_table_engine_tb.sv
// ----------------------------------------------------------------------------
// cheat_code_table_engine_tb: self-checking bench for the cheat table engine
// Drives add, remove, enable, disable, vblank, clear and unused commands,
// tracks the table contents in a local shadow copy and checks every result
// beat, field by field, in order against the shadow's prediction.
// ----------------------------------------------------------------------------
module cheat_code_table_engine_tb;
  import cct_pkg::*;

  localparam int RandomItems = 320;
  localparam int CycleLimit  = 200000;

  typedef struct {
    cmd_t cmd;
    bit   drain_first;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t command = '0;
  logic busy;
  logic result_valid;
  rsp_t result;

  pending_t    pending_items[$];
  rsp_t        expected_results[$];
  entry_t      shadow_table[$];
  logic [31:0] id_pool[$];

  int unsigned total_items    = 0;
  int unsigned accepted_count = 0;
  int unsigned results_due    = 0;
  int unsigned results_taken  = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  cheat_code_table_engine u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Returns {bad, nibble} for one ASCII character.
  function automatic logic [4:0] ascii_to_nibble(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b0, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic logic [7:0] nibble_to_ascii(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [31:0] code_nibbles(input logic [7:0] kind,
                                               input logic [7:0] value,
                                               input logic [15:0] addr);
    return {kind, value, addr};
  endfunction

  // Character i carries nibble i of {kind, value, addr}, most significant first.
  function automatic logic [63:0] make_code(input logic [7:0] kind, input logic [7:0] value,
                                            input logic [15:0] addr, input logic [7:0] lower);
    logic [31:0] n;
    logic [63:0] text;
    n = code_nibbles(kind, value, addr);
    for (int i = 0; i < 8; i++) begin
      text[8*i +: 8] = nibble_to_ascii(n[28 - 4*i +: 4], lower[i]);
    end
    return text;
  endfunction

  function automatic logic [31:0] code_id_of(input logic [7:0] value, input logic [15:0] addr);
    logic [31:0] n;
    logic [31:0] id;
    n = code_nibbles(CodeType, value, addr);
    for (int i = 0; i < 8; i++) begin
      id[4*i +: 4] = n[28 - 4*i +: 4];
    end
    return id;
  endfunction

  function automatic rsp_t make_result(input logic [2:0] st, input logic [31:0] id,
                                       input logic wv, input logic [15:0] addr,
                                       input logic [7:0] value, input logic fin);
    rsp_t r;
    r.status      = st;
    r.result_id   = id;
    r.write_valid = wv;
    r.write_addr  = addr;
    r.write_value = value;
    r.last        = fin;
    return r;
  endfunction

  function automatic int find_entry(input logic [31:0] id);
    foreach (shadow_table[i]) begin
      if (shadow_table[i].id == id) return i;
    end
    return -1;
  endfunction

  task automatic expect_result(input rsp_t r);
    expected_results.push_back(r);
    results_due++;
  endtask

  // Updates the shadow table for one accepted command and queues its results.
  task automatic predict_results(input cmd_t c);
    logic [4:0]  dec;
    logic [3:0]  nib[8];
    logic        bad;
    entry_t      e;
    logic [31:0] id;
    int          idx;
    int          enabled_total;
    int          k;
    bad = 1'b0;
    case (c.operation)
      OP_ADD: begin
        for (int i = 0; i < 8; i++) begin
          dec = ascii_to_nibble(c.code_text[8*i +: 8]);
          bad |= dec[4];
          nib[i] = dec[3:0];
        end
        if (bad) begin
          expect_result(make_result(ST_BAD_CHAR, '0, 1'b0, '0, '0, 1'b1));
        end else if ({nib[0], nib[1]} != CodeType) begin
          expect_result(make_result(ST_BAD_TYPE, '0, 1'b0, '0, '0, 1'b1));
        end else if (shadow_table.size() >= TableDepth) begin
          expect_result(make_result(ST_FULL, '0, 1'b0, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < 8; i++) id[4*i +: 4] = nib[i];
          e.addr    = {nib[4], nib[5], nib[6], nib[7]};
          e.value   = {nib[2], nib[3]};
          e.id      = id;
          e.enabled = 1'b1;
          shadow_table.push_back(e);
          expect_result(make_result(ST_OK, id, 1'b0, '0, '0, 1'b1));
        end
      end
      OP_REMOVE, OP_ENABLE, OP_DISABLE: begin
        idx = find_entry(c.code_id);
        if (idx < 0) begin
          expect_result(make_result(ST_NOT_FOUND, '0, 1'b0, '0, '0, 1'b1));
        end else begin
          if (c.operation == OP_REMOVE) begin
            shadow_table.delete(idx);
          end else begin
            e = shadow_table[idx];
            e.enabled = (c.operation == OP_ENABLE);
            shadow_table[idx] = e;
          end
          expect_result(make_result(ST_OK, '0, 1'b0, '0, '0, 1'b1));
        end
      end
      OP_VBLANK: begin
        enabled_total = 0;
        foreach (shadow_table[i]) if (shadow_table[i].enabled) enabled_total++;
        if (enabled_total == 0) begin
          expect_result(make_result(ST_OK, '0, 1'b0, '0, '0, 1'b1));
        end else begin
          k = 0;
          foreach (shadow_table[i]) begin
            if (shadow_table[i].enabled) begin
              k++;
              expect_result(make_result(ST_OK, '0, 1'b1, shadow_table[i].addr,
                                        shadow_table[i].value, k == enabled_total));
            end
          end
        end
      end
      OP_CLEAR: begin
        shadow_table.delete();
        expect_result(make_result(ST_OK, '0, 1'b0, '0, '0, 1'b1));
      end
      default: begin
        expect_result(make_result(ST_OK, '0, 1'b0, '0, '0, 1'b1));
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (error_count < 40) begin
      $display("cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
    end
    error_count++;
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic queue_item(input logic [2:0] op, input logic [63:0] text,
                            input logic [31:0] id, input bit drain);
    pending_t p;
    p.cmd.operation = op;
    p.cmd.code_text = text;
    p.cmd.code_id   = id;
    p.drain_first   = drain;
    pending_items.push_back(p);
  endtask

  task automatic queue_add(input logic [7:0] value, input logic [15:0] addr,
                           input logic [7:0] lower);
    id_pool.push_back(code_id_of(value, addr));
    queue_item(OP_ADD, make_code(CodeType, value, addr, lower), $urandom, 1'b0);
  endtask

  function automatic logic [31:0] pick_id();
    if (id_pool.size() != 0 && $urandom_range(9) < 8) begin
      return id_pool[$urandom_range(id_pool.size() - 1)];
    end
    return $urandom;
  endfunction

  function automatic logic [7:0] rand_value();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_addr();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random_add();
    queue_add(rand_value(), rand_addr(), 8'($urandom));
  endtask

  task automatic queue_wrong_type();
    logic [7:0] kind;
    kind = 8'($urandom);
    if (kind == CodeType) kind = 8'h10;
    queue_item(OP_ADD, make_code(kind, rand_value(), rand_addr(), 8'($urandom)),
               $urandom, 1'b0);
  endtask

  // A well-formed code with one byte replaced by a character that is not hex.
  task automatic queue_bad_char();
    logic [63:0] text;
    logic [7:0]  c;
    logic [4:0]  dec;
    text = make_code(CodeType, rand_value(), rand_addr(), 8'($urandom));
    c = 8'($urandom);
    dec = ascii_to_nibble(c);
    while (!dec[4]) begin
      c = 8'($urandom);
      dec = ascii_to_nibble(c);
    end
    text[8*$urandom_range(7) +: 8] = c;
    queue_item(OP_ADD, text, $urandom, 1'b0);
  endtask

  function automatic logic [63:0] rand_text();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_directed();
    logic [63:0] text;
    queue_item(OP_VBLANK, rand_text(), $urandom, 1'b0);
    queue_item(OP_REMOVE, rand_text(), 32'h0000_0010, 1'b0);
    queue_add(8'hFF, 16'hFFFF, 8'h00);
    queue_add(8'h00, 16'h0000, 8'h00);
    queue_add(8'hAB, 16'hCDEF, 8'hFF);
    queue_add(8'hFF, 16'hFFFF, 8'h5A);
    queue_item(OP_ADD, 64'h0, 32'h0, 1'b0);
    queue_item(OP_ADD, '1, '1, 1'b0);
    // Wrong type and a bad character together: the character check wins.
    text = make_code(8'h02, 8'h12, 16'h3456, 8'h00);
    text[47:40] = 8'h67;
    queue_item(OP_ADD, text, $urandom, 1'b0);
    queue_item(OP_ADD, make_code(8'h02, 8'h12, 16'h3456, 8'h00), $urandom, 1'b0);
    queue_item(OP_ADD, make_code(8'h10, 8'h12, 16'h3456, 8'h00), $urandom, 1'b0);
    queue_item(OP_VBLANK, rand_text(), $urandom, 1'b0);
    queue_item(OP_DISABLE, rand_text(), code_id_of(8'hFF, 16'hFFFF), 1'b0);
    queue_item(OP_VBLANK, rand_text(), $urandom, 1'b0);
    queue_item(OP_ENABLE, rand_text(), code_id_of(8'hFF, 16'hFFFF), 1'b0);
    queue_item(OP_DISABLE, rand_text(), code_id_of(8'h00, 16'h0000), 1'b0);
    queue_item(OP_ENABLE, rand_text(), 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_DISABLE, rand_text(), 32'h0000_0000, 1'b0);
    queue_item(OP_REMOVE, rand_text(), code_id_of(8'hFF, 16'hFFFF), 1'b0);
    queue_item(OP_VBLANK, rand_text(), $urandom, 1'b0);
    queue_item(3'd6, rand_text(), $urandom, 1'b0);
    queue_item(3'd7, '1, '1, 1'b0);
    queue_item(OP_CLEAR, rand_text(), $urandom, 1'b1);
    queue_item(OP_VBLANK, rand_text(), $urandom, 1'b0);
    id_pool.delete();
  endtask

  // Sessions: an optional clear (always in the first), a fill with random codes,
  // then edits and vblanks on ids mostly in the table, with malformed commands mixed in.
  task automatic queue_random();
    int unsigned issued;
    int unsigned fill;
    int unsigned edits;
    int unsigned r;
    bit          first;
    issued = 0;
    first  = 1'b1;
    while (issued < RandomItems) begin
      if (first || $urandom_range(9) < 6) begin
        queue_item(OP_CLEAR, rand_text(), $urandom, first || $urandom_range(3) == 0);
        id_pool.delete();
        issued++;
      end
      fill = first ? TableDepth + 1 : $urandom_range(1, TableDepth + 2);
      for (int i = 0; i < fill; i++) queue_random_add();
      issued += fill;
      edits = $urandom_range(4, 20);
      for (int i = 0; i < edits; i++) begin
        r = $urandom_range(99);
        if (r < 20)      queue_item(OP_REMOVE, rand_text(), pick_id(), 1'b0);
        else if (r < 35) queue_item(OP_ENABLE, rand_text(), pick_id(), 1'b0);
        else if (r < 50) queue_item(OP_DISABLE, rand_text(), pick_id(), 1'b0);
        else if (r < 65) queue_item(OP_VBLANK, rand_text(), $urandom, 1'b0);
        else if (r < 75) queue_random_add();
        else if (r < 80) queue_wrong_type();
        else if (r < 85) queue_bad_char();
        else if (r < 89) queue_item(OP_ADD, rand_text(), $urandom, 1'b0);
        else if (r < 95) queue_item(3'($urandom_range(6, 7)), rand_text(), $urandom, 1'b0);
        else begin
          queue_item(OP_CLEAR, rand_text(), $urandom, 1'b0);
          id_pool.delete();
        end
      end
      issued += edits;
      first = 1'b0;
    end
  endtask

  // ------------------------------------------------------------------ driver

  function automatic int unsigned sender_idle_pct();
    if (accepted_count < total_items / 3) return 6;
    if (accepted_count < 2 * total_items / 3) return 60;
    return 0;
  endfunction

  always @(posedge clk) begin : drive
    logic     next_start;
    cmd_t     next_cmd;
    pending_t head;
    next_start = start;
    next_cmd   = command;
    if (rst) begin
      next_start = 1'b0;
    end else begin
      if (start && !busy) begin
        predict_results(command);
        accepted_count++;
        next_start = 1'b0;
      end
      if (!next_start && pending_items.size() != 0) begin
        head = pending_items[0];
        if ($urandom_range(99) >= sender_idle_pct() &&
            !(head.drain_first && results_due != results_taken)) begin
          void'(pending_items.pop_front());
          next_cmd   = head.cmd;
          next_start = 1'b1;
        end
      end
    end
    start   <= next_start;
    command <= next_cmd;
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk) begin : check
    rsp_t want;
    if (!rst && result_valid) begin
      results_taken <= results_taken + 1;
      if (expected_results.size() == 0) begin
        note_mismatch("result beat with nothing expected, status", 64'(result.status), '0);
      end else begin
        want = expected_results.pop_front();
        if (result.status != want.status)
          note_mismatch("status", 64'(result.status), 64'(want.status));
        if (result.result_id != want.result_id)
          note_mismatch("result_id", 64'(result.result_id), 64'(want.result_id));
        if (result.write_valid != want.write_valid)
          note_mismatch("write_valid", 64'(result.write_valid), 64'(want.write_valid));
        if (result.write_addr != want.write_addr)
          note_mismatch("write_addr", 64'(result.write_addr), 64'(want.write_addr));
        if (result.write_value != want.write_value)
          note_mismatch("write_value", 64'(result.write_value), 64'(want.write_value));
        if (result.last != want.last)
          note_mismatch("last", 64'(result.last), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("cheat_code_table_engine_tb: done, errors");
      $finish;
    end
  end

  initial begin
    queue_directed();
    queue_random();
    total_items = pending_items.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TableDepth + 4) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_mismatch("beats never delivered", 64'(expected_results.size()), '0);
    end
    if (error_count == 0) begin
      $display("cheat_code_table_engine_tb: done, clean");
    end else begin
      $display("cheat_code_table_engine_tb: done, errors");
    end
    $finish;
  end

endmodule
